/* design/ffxp_pkg.sv */
// Package for the fixed frame XOR parser: constants, state enum, command and status types.
package ffxp_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int CK_FIRST    = 2;
  localparam int CK_COUNT    = 7;
  localparam int CK_POS      = 9;
  localparam int TAIL_POS0   = 10;
  localparam int TAIL_POS1   = 11;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] fill_t;

  localparam byte_t HDR_BYTE  = 8'hAA;
  localparam byte_t LEN_BYTE  = 8'h06;
  localparam byte_t TAIL_BYTE = 8'h55;
  localparam fill_t LAST_POS  = fill_t'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HEAD,
    ST_BODY
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic wr;      // store the byte at the fill position
    logic clr;     // empty the store
    logic resync;  // realign on the next header pair, else on a lone header byte at the end
    logic emit;    // load the result registers
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hdr;        // incoming byte is a header byte
    logic last;       // incoming byte completes the frame
    logic frame_ok;   // completed frame passes all checks
    logic keep_zero;  // resync keeps nothing
    logic keep_one;   // resync keeps a single header byte
  } sts_t;

endpackage

/* design/ffxp_dp.sv */
// Datapath: frame store, fill count, frame check, resync shift and result registers.
module ffxp_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            rx_byte_i,
  input  ffxp_pkg::cmd_t        cmd_i,
  output ffxp_pkg::sts_t        sts_o,
  output logic [7:0]            first_id_o,
  output logic signed [15:0]    first_error_o,
  output logic [7:0]            second_id_o,
  output logic signed [15:0]    second_error_o
);

  ffxp_pkg::byte_t store_q [ffxp_pkg::FRAME_BYTES];
  ffxp_pkg::byte_t store_d [ffxp_pkg::FRAME_BYTES];
  ffxp_pkg::byte_t full    [ffxp_pkg::FRAME_BYTES];
  ffxp_pkg::fill_t fill_q, fill_d;
  ffxp_pkg::fill_t shift;
  ffxp_pkg::fill_t kept;
  ffxp_pkg::byte_t ck;
  logic            found;

  // store as it stands once the incoming byte is the last one
  always_comb begin
    for (int k = 0; k < ffxp_pkg::FRAME_BYTES; k++) begin
      full[k] = store_q[k];
    end
    full[ffxp_pkg::FRAME_BYTES-1] = rx_byte_i;
  end

  always_comb begin
    ck = '0;
    for (int k = 0; k < ffxp_pkg::CK_COUNT; k++) begin
      ck = ck ^ full[ffxp_pkg::CK_FIRST + k];
    end
  end

  // first header pair at positions 1..10, else a lone header at the end
  always_comb begin
    found = 1'b0;
    shift = '0;
    for (int i = ffxp_pkg::FRAME_BYTES - 1; i >= 1; i--) begin
      if (i == ffxp_pkg::FRAME_BYTES - 1) begin
        if (full[i] == ffxp_pkg::HDR_BYTE) begin
          found = 1'b1;
          shift = ffxp_pkg::fill_t'(i);
        end
      end else if (full[i] == ffxp_pkg::HDR_BYTE && full[i+1] == ffxp_pkg::HDR_BYTE) begin
        found = 1'b1;
        shift = ffxp_pkg::fill_t'(i);
      end
    end
    kept = found ? ffxp_pkg::fill_t'(ffxp_pkg::FRAME_BYTES) - shift : '0;
  end

  always_comb begin
    sts_o.hdr       = (rx_byte_i == ffxp_pkg::HDR_BYTE);
    sts_o.last      = (fill_q == ffxp_pkg::LAST_POS);
    sts_o.frame_ok  = (full[0] == ffxp_pkg::HDR_BYTE) && (full[1] == ffxp_pkg::HDR_BYTE) &&
                      (full[2] == ffxp_pkg::LEN_BYTE) &&
                      (full[ffxp_pkg::TAIL_POS0] == ffxp_pkg::TAIL_BYTE) &&
                      (full[ffxp_pkg::TAIL_POS1] == ffxp_pkg::TAIL_BYTE) &&
                      (ck == full[ffxp_pkg::CK_POS]);
    sts_o.keep_zero = !found;
    sts_o.keep_one  = found && (kept == ffxp_pkg::fill_t'(1));
  end

  always_comb begin
    for (int k = 0; k < ffxp_pkg::FRAME_BYTES; k++) begin
      store_d[k] = store_q[k];
    end
    fill_d = fill_q;
    if (cmd_i.wr) begin
      store_d[fill_q] = rx_byte_i;
      fill_d          = fill_q + ffxp_pkg::fill_t'(1);
    end
    if (cmd_i.resync) begin
      for (int k = 0; k < ffxp_pkg::FRAME_BYTES; k++) begin
        for (int i = 1; i < ffxp_pkg::FRAME_BYTES; i++) begin
          if (shift == ffxp_pkg::fill_t'(i) && k + i < ffxp_pkg::FRAME_BYTES) begin
            store_d[k] = full[k+i];
          end
        end
      end
      fill_d = kept;
    end
    if (cmd_i.clr) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ffxp_pkg::FRAME_BYTES; k++) begin
      store_q[k] <= store_d[k];
    end
    if (cmd_i.emit) begin
      first_id_o     <= full[3];
      first_error_o  <= {full[4], full[5]};
      second_id_o    <= full[6];
      second_error_o <= {full[7], full[8]};
    end
  end

endmodule

/* design/ffxp_ctrl.sv */
// Controller: frame phase state machine and the handshakes of both channels.
module ffxp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ffxp_pkg::sts_t sts_i,
  output ffxp_pkg::cmd_t cmd_o
);

  ffxp_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    if (accept) begin
      unique case (state_q)
        ffxp_pkg::ST_HUNT: begin
          if (sts_i.hdr) state_d = ffxp_pkg::ST_HEAD;
        end
        ffxp_pkg::ST_HEAD: begin
          state_d = sts_i.hdr ? ffxp_pkg::ST_BODY : ffxp_pkg::ST_HUNT;
        end
        ffxp_pkg::ST_BODY: begin
          if (sts_i.last) begin
            priority if (sts_i.frame_ok) state_d = ffxp_pkg::ST_HUNT;
            else if (sts_i.keep_zero)    state_d = ffxp_pkg::ST_HUNT;
            else if (sts_i.keep_one)     state_d = ffxp_pkg::ST_HEAD;
            else                         state_d = ffxp_pkg::ST_BODY;
          end
        end
        default: state_d = ffxp_pkg::ST_HUNT;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    if (accept) begin
      unique case (state_q)
        ffxp_pkg::ST_HUNT: begin
          cmd_o.wr = sts_i.hdr;
        end
        ffxp_pkg::ST_HEAD: begin
          cmd_o.wr  = sts_i.hdr;
          cmd_o.clr = !sts_i.hdr;
        end
        ffxp_pkg::ST_BODY: begin
          if (!sts_i.last) begin
            cmd_o.wr = 1'b1;
          end else if (sts_i.frame_ok) begin
            cmd_o.emit = 1'b1;
            cmd_o.clr  = 1'b1;
          end else begin
            cmd_o.resync = 1'b1;
          end
        end
        default: cmd_o.clr = 1'b1;
      endcase
    end
  end

  always_comb begin
    out_valid_d = cmd_o.emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffxp_pkg::ST_HUNT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* design/fixed_frame_xor_parser_top.sv */
// Top level of the fixed frame XOR parser.
// Throughput: one byte item per cycle while the result register is free or being taken.
// A result shows on out_valid_o in the cycle after the twelfth byte of a good frame is accepted.
// in_ready_o drops only while a result waits in the single output register.
// Reset (rst_ni low, asynchronous) empties the store, returns to header hunt, clears out_valid_o.
module fixed_frame_xor_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         first_id_o,
  output logic signed [15:0] first_error_o,
  output logic [7:0]         second_id_o,
  output logic signed [15:0] second_error_o
);

  ffxp_pkg::cmd_t cmd;
  ffxp_pkg::sts_t sts;

  ffxp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffxp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .first_id_o     (first_id_o),
    .first_error_o  (first_error_o),
    .second_id_o    (second_id_o),
    .second_error_o (second_error_o)
  );

endmodule

/* design/ffxp_checker.sv */
// Port-level checker for the fixed frame XOR parser, bound to the top level.
module ffxp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         rx_byte_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         first_id_o,
  input logic signed [15:0] first_error_o,
  input logic [7:0]         second_id_o,
  input logic signed [15:0] second_error_o
);

  a_reset_clears: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !($past(out_valid_o) && !$past(out_ready_i))) |->
      $past(in_valid_i && in_ready_o))
    else $error("new result without an accepted item");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_id_o) &&
      $stable(first_error_o) && $stable(second_id_o) && $stable(second_error_o))
    else $error("stalled result changed");

endmodule

bind fixed_frame_xor_parser_top ffxp_checker u_ffxp_checker (.*);
